### hw/rtl/assert_macros.svh
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, sampled on clk, off while rst_n is low
`define SWM_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication, sampled on clk, off while rst_n is low
`define SWM_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

### hw/rtl/swm_pkg.sv
// types and constants of the sliding window median time block
package swm_pkg;

    localparam int unsigned TS_W     = 32;
    localparam int unsigned CNT_OUT_W = 4;

    typedef struct packed {
        logic [TS_W-1:0] timestamp;
        logic            start_new_chain;
    } in_t;

    typedef struct packed {
        logic [TS_W-1:0]      median_time;
        logic [CNT_OUT_W-1:0] window_count;
    } out_t;

    // controls from the sequencer to the rank unit
    typedef struct packed {
        logic clear;
        logic step;
        logic earlier;
    } rank_ctl_t;

endpackage

### hw/rtl/swm_ram.sv
// generic single write, single read ram with registered read data
module swm_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 11
) (
    input  logic                                    clk,
    input  logic                                    wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                        wr_data,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                        rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        rd_data <= mem_reg[rd_addr];
    end

endmodule

### hw/rtl/swm_rank_unit.sv
// shared compare unit that counts how many window entries sort before the candidate
module swm_rank_unit #(
    parameter int unsigned COUNT_W = 4
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  swm_pkg::rank_ctl_t           ctl,
    input  logic [swm_pkg::TS_W-1:0]     cand,
    input  logic [swm_pkg::TS_W-1:0]     data,
    output logic [COUNT_W-1:0]           rank_sum
);

    logic               precedes;
    logic [COUNT_W-1:0] rank_reg;
    logic [COUNT_W-1:0] rank_next;

    // equal values are ordered by slot so that every entry gets a distinct rank
    assign precedes = (data < cand) || ((data == cand) && ctl.earlier);
    assign rank_sum = rank_reg + COUNT_W'(precedes);

    always_comb
    begin
        rank_next = rank_reg;
        if (ctl.clear)
        begin
            rank_next = '0;
        end
        else if (ctl.step)
        begin
            rank_next = rank_sum;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rank_reg <= '0;
        end
        else
        begin
            rank_reg <= rank_next;
        end
    end

endmodule

### hw/rtl/sliding_window_median_time_top.sv
// top level of the sliding window median time block
// usage:
// - item channel (item_valid, item_stall, item): one block timestamp per item in
//   chain order, oldest first; start_new_chain empties the window before the
//   timestamp goes in
// - result channel (result_valid, result_stall, result): one result per item,
//   the median of the held timestamps (upper median for an even count) and
//   the number of timestamps held
// - an item is taken when valid is high and stall is low at a rising clk edge
// - timing: with n timestamps held, every candidate costs one pass of n
//   reads through the single read port of the window ram and the single
//   compare unit
// - item_stall is high from the cycle after an item is taken until its
//   result is loaded into the output register
// - the output register holds a result while result_stall is high; the next
//   item is still taken, and its finished result waits inside the block
//   until the output register frees up
// - reset (rst_n low, asynchronous) empties the window and drops any result;
//   no clearing pass is needed since only written slots are ever read
module sliding_window_median_time_top #(
    parameter int unsigned WINDOW_SIZE = 11
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          item_valid,
    output logic          item_stall,
    input  swm_pkg::in_t  item,
    output logic          result_valid,
    input  logic          result_stall,
    output swm_pkg::out_t result
);

    localparam int unsigned AW = (WINDOW_SIZE > 1) ? $clog2(WINDOW_SIZE) : 1;
    localparam int unsigned CW = $clog2(WINDOW_SIZE + 1);

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_CAND = 5'b00010,
        S_LOAD = 5'b00100,
        S_SCAN = 5'b01000,
        S_DONE = 5'b10000
    } state_t;

    state_t                    state_reg, state_next;
    logic [CW-1:0]             fill_reg, fill_next;     // timestamps held
    logic [AW-1:0]             slot_reg, slot_next;     // slot for the next timestamp
    logic [AW-1:0]             c_reg, c_next;           // candidate slot
    logic [AW-1:0]             j_reg, j_next;           // slot whose data is on rd_data
    logic [swm_pkg::TS_W-1:0]  cand_reg, cand_next;
    swm_pkg::out_t             result_reg, result_next;
    logic                      result_valid_reg, result_valid_next;

    logic                      accept;
    logic [CW-1:0]             fill_base;
    logic [AW-1:0]             slot_base;
    logic [AW-1:0]             rd_addr;
    logic [swm_pkg::TS_W-1:0]  rd_data;
    logic                      last_j;
    logic                      found;
    logic                      load_out;
    logic [CW-1:0]             rank_sum;
    swm_pkg::rank_ctl_t        rank_ctl;
    logic [CW+3:0]             count_ext;

    assign item_stall   = (state_reg != S_IDLE);
    assign accept       = item_valid && !item_stall;
    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    // a restart drops the window before this timestamp is written
    assign fill_base = item.start_new_chain ? '0 : fill_reg;
    assign slot_base = item.start_new_chain ? '0 : slot_reg;

    assign last_j = (CW'(j_reg) == (fill_reg - CW'(1)));
    // the median is the entry with exactly fill/2 entries sorting before it
    assign found  = (rank_sum == (fill_reg >> 1));

    assign load_out  = (state_reg == S_DONE) && (!result_valid_reg || !result_stall);
    assign count_ext = {4'b0000, fill_reg};

    // read address: candidate first, then a sweep over every held slot
    always_comb
    begin
        case (state_reg)
            S_CAND:  rd_addr = c_reg;
            S_SCAN:  rd_addr = last_j ? '0 : AW'(j_reg + 1'b1);
            default: rd_addr = '0;
        endcase
    end

    assign rank_ctl.clear   = (state_reg == S_LOAD);
    assign rank_ctl.step    = (state_reg == S_SCAN);
    assign rank_ctl.earlier = (j_reg < c_reg);

    swm_ram #(
        .WIDTH (swm_pkg::TS_W),
        .DEPTH (WINDOW_SIZE)
    ) u_window (
        .clk     (clk),
        .wr_en   (accept),
        .wr_addr (slot_base),
        .wr_data (item.timestamp),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    swm_rank_unit #(
        .COUNT_W (CW)
    ) u_rank (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctl      (rank_ctl),
        .cand     (cand_reg),
        .data     (rd_data),
        .rank_sum (rank_sum)
    );

    // sequencer
    always_comb
    begin
        state_next        = state_reg;
        fill_next         = fill_reg;
        slot_next         = slot_reg;
        c_next            = c_reg;
        j_next            = j_reg;
        cand_next         = cand_reg;
        result_next       = result_reg;
        result_valid_next = result_valid_reg;

        if (result_valid_reg && !result_stall)
        begin
            result_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    fill_next  = (fill_base == CW'(WINDOW_SIZE)) ? fill_base
                                                                 : CW'(fill_base + 1'b1);
                    slot_next  = (slot_base == AW'(WINDOW_SIZE - 1)) ? '0
                                                                     : AW'(slot_base + 1'b1);
                    c_next     = '0;
                    state_next = S_CAND;
                end
            end
            S_CAND:
            begin
                state_next = S_LOAD;
            end
            S_LOAD:
            begin
                // candidate arrives, first sweep read is in flight
                cand_next  = rd_data;
                j_next     = '0;
                state_next = S_SCAN;
            end
            S_SCAN:
            begin
                if (last_j)
                begin
                    if (found)
                    begin
                        state_next = S_DONE;
                    end
                    else
                    begin
                        c_next     = AW'(c_reg + 1'b1);
                        state_next = S_CAND;
                    end
                end
                else
                begin
                    j_next = AW'(j_reg + 1'b1);
                end
            end
            S_DONE:
            begin
                if (load_out)
                begin
                    result_next.median_time  = cand_reg;
                    result_next.window_count = count_ext[3:0];
                    result_valid_next        = 1'b1;
                    state_next               = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            fill_reg         <= '0;
            slot_reg         <= '0;
            c_reg            <= '0;
            j_reg            <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            fill_reg         <= fill_next;
            slot_reg         <= slot_next;
            c_reg            <= c_next;
            j_reg            <= j_next;
            result_valid_reg <= result_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        cand_reg   <= cand_next;
        result_reg <= result_next;
    end

endmodule

### hw/rtl/swm_checker.sv
// port level checker for the sliding window median time block, with its bind
`include "assert_macros.svh"

module swm_checker #(
    parameter int unsigned WINDOW_SIZE = 11
) (
    input logic          clk,
    input logic          rst_n,
    input logic          item_valid,
    input logic          item_stall,
    input swm_pkg::in_t  item,
    input logic          result_valid,
    input logic          result_stall,
    input swm_pkg::out_t result
);

    // the block is busy right after taking an item
    `SWM_ASSERT_NEXT(a_busy_after_item, item_valid && !item_stall, item_stall)

    // a fresh result lands in the same edge that frees the item side
    `SWM_ASSERT_NOW(a_free_with_result, $rose(result_valid), !item_stall)

    // count stays inside the window when it fits the field
    `SWM_ASSERT_NOW(a_count_range, result_valid && (WINDOW_SIZE < 16),
        (result.window_count != 4'd0) && (result.window_count <= WINDOW_SIZE))

    // a stalled result holds
    `SWM_ASSERT_NEXT(a_result_hold, result_valid && result_stall,
        result_valid && $stable(result))

endmodule

bind sliding_window_median_time_top swm_checker #(
    .WINDOW_SIZE (WINDOW_SIZE)
) u_swm_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .item         (item),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
);

### sim/tb_top.sv
// self-checking testbench of the sliding window median time block
module tb_top;

    timeunit 1ns;
    timeprecision 1ps;

    // window depth of the block under test, also used by the shadow window
    localparam int unsigned WINDOW_SIZE = 11;
    // settle window after the drain, with margin over the worst result latency
    localparam int unsigned SETTLE_CYCLES = 200;
    // cycles with no item moving on either channel before the run is called hung
    localparam int unsigned WATCHDOG_LIMIT = 5000;

    logic           clk = 1'b0;
    logic           rst_n = 1'b0;
    logic           item_valid = 1'b0;
    logic           item_stall;
    swm_pkg::in_t   item = '0;
    logic           result_valid;
    logic           result_stall = 1'b0;
    swm_pkg::out_t  result;

    // free-running clock, 10 ns period
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    sliding_window_median_time_top #(
        .WINDOW_SIZE (WINDOW_SIZE)
    ) i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

    // shadow copy of the block's window: circular store, fill level, next write slot
    logic [swm_pkg::TS_W-1:0] shadow_times [WINDOW_SIZE];
    int unsigned              shadow_held = 0;
    int unsigned              shadow_slot = 0;

    // medians predicted for accepted items, oldest first
    swm_pkg::out_t pending_medians [$];

    // idle rates in percent for the two sides
    int unsigned send_idle_pct = 0;
    int unsigned recv_idle_pct = 0;

    // bookkeeping for the summary and the verdict
    int unsigned error_count = 0;
    int unsigned items_sent = 0;
    int unsigned restarts_sent = 0;
    int unsigned results_checked = 0;
    int unsigned full_windows = 0;
    int unsigned quiet_cycles = 0;

    initial
    begin
        for (int k = 0; k < WINDOW_SIZE; k++)
            shadow_times[k] = '0;
    end

    // one line per mismatch, counted for the verdict
    task automatic report_mismatch(input string what,
                                   input logic [swm_pkg::TS_W-1:0] got,
                                   input logic [swm_pkg::TS_W-1:0] want);
        $display("%0t mismatch: %s got %0h expected %0h (result %0d)",
                 $realtime, what, got, want, results_checked);
        error_count++;
    endtask

    // update the shadow window with one item and work out its median
    function automatic swm_pkg::out_t predict_median(input swm_pkg::in_t it);
        logic [swm_pkg::TS_W-1:0] sorted [WINDOW_SIZE];
        logic [swm_pkg::TS_W-1:0] key;
        int                       i;
        int                       j;
        swm_pkg::out_t            r;
        // a restart empties the window before the new timestamp goes in
        if (it.start_new_chain)
        begin
            shadow_held = 0;
            shadow_slot = 0;
        end
        shadow_times[shadow_slot] = it.timestamp;
        shadow_slot++;
        if (shadow_slot >= WINDOW_SIZE)
            shadow_slot = 0;
        if (shadow_held < WINDOW_SIZE)
            shadow_held++;
        // while filling, slots 0 .. held-1 are the live ones; once full, all are
        for (i = 0; i < shadow_held; i++)
            sorted[i] = shadow_times[i];
        for (i = 1; i < shadow_held; i++)
        begin
            key = sorted[i];
            j = i;
            while (j > 0 && sorted[j-1] > key)
            begin
                sorted[j] = sorted[j-1];
                j--;
            end
            sorted[j] = key;
        end
        // upper median when the count is even
        r.median_time  = sorted[shadow_held / 2];
        r.window_count = shadow_held[swm_pkg::CNT_OUT_W-1:0];
        return r;
    endfunction

    // present one item, hold it until taken, then record the expected median
    task automatic send_item(input logic [swm_pkg::TS_W-1:0] ts, input logic restart);
        swm_pkg::in_t it;
        it.timestamp = ts;
        it.start_new_chain = restart;
        // random gap before the item; valid drops only when a gap is taken
        while ($urandom_range(99) < send_idle_pct)
        begin
            item_valid <= 1'b0;
            @(posedge clk);
        end
        item_valid <= 1'b1;
        item <= it;
        // taken at the first edge with valid high and stall low
        do
            @(posedge clk);
        while (item_stall);
        pending_medians.push_back(predict_median(it));
        items_sent++;
        if (restart)
            restarts_sent++;
    endtask

    // pick the next timestamp of a chain in one of several styles
    function automatic logic [swm_pkg::TS_W-1:0] next_timestamp(
        input int unsigned              style,
        input logic [swm_pkg::TS_W-1:0] prev);
        logic [swm_pkg::TS_W-1:0] v;
        case (style)
            0: v = $urandom;
            // realistic drift, sometimes going backwards, wrapping at the top
            1: v = prev + $urandom_range(1200) - 32'd600;
            // tiny range so that duplicates are common
            2: v = $urandom_range(7);
            default:
            begin
                case ($urandom_range(4))
                    0: v = '0;
                    1: v = '1;
                    2: v = 32'h8000_0000;
                    3: v = 32'h7fff_ffff;
                    default: v = $urandom;
                endcase
            end
        endcase
        return v;
    endfunction

    // send one chain: a restart first when lead_restart is set, then len-1 items, with a rare stray restart
    task automatic send_chain(input int unsigned len, input bit lead_restart);
        logic [swm_pkg::TS_W-1:0] ts;
        int unsigned              style;
        logic                     restart;
        style = $urandom_range(3);
        ts = $urandom;
        for (int unsigned k = 0; k < len; k++)
        begin
            ts = next_timestamp(style, ts);
            restart = (k == 0) ? lead_restart : ($urandom_range(99) < 4);
            // occasional switch of style inside a chain
            if ($urandom_range(99) < 10)
                style = $urandom_range(3);
            send_item(ts, restart);
        end
    endtask

    // hold the sender until every expected median has come back
    task automatic wait_results_drained();
        while (pending_medians.size() != 0)
            @(posedge clk);
    endtask

    // directed: extremes, even counts, first fill, wrap of the window, restarts
    task automatic test_window_edges();
        // first item after reset without a restart
        send_item(32'haaaa_aaaa, 1'b0);
        // restart with the lowest timestamp: window of one
        send_item(32'h0000_0000, 1'b1);
        // count two: upper median picks the larger value
        send_item(32'hffff_ffff, 1'b0);
        send_item(32'h0000_0001, 1'b0);
        // restart with the highest timestamp
        send_item(32'hffff_ffff, 1'b1);
        // descending run fills the window and wraps past the oldest slot
        for (int k = 0; k < 12; k++)
            send_item(32'hf000_0000 - k * 32'h1111_1111, 1'b0);
        // restart again, then equal values
        send_item(32'h7fff_ffff, 1'b1);
        send_item(32'h8000_0000, 1'b0);
        send_item(32'h8000_0000, 1'b0);
        send_item(32'h8000_0000, 1'b0);
        // alternating extremes
        send_item(32'h0000_0000, 1'b0);
        send_item(32'hffff_ffff, 1'b0);
        send_item(32'h0000_0000, 1'b0);
        send_item(32'h5555_5555, 1'b0);
    endtask

    // random chains of mixed lengths, some short, many past the full window
    task automatic test_random_chains(input int unsigned n_items);
        int unsigned done_items;
        int unsigned len;
        done_items = 0;
        while (done_items < n_items)
        begin
            case ($urandom_range(3))
                0: len = $urandom_range(1, 4);
                1: len = $urandom_range(5, WINDOW_SIZE);
                default: len = $urandom_range(WINDOW_SIZE + 1, 40);
            endcase
            // most chains open with a restart; a few run on from the last one
            send_chain(len, $urandom_range(99) < 90);
            done_items += len;
        end
    endtask

    // sender pauses with nothing outstanding, then picks up mid chain
    task automatic test_drain_pause();
        send_chain(15, 1'b1);
        item_valid <= 1'b0;
        wait_results_drained();
        send_chain(8, 1'b0);
        send_chain(6, 1'b1);
    endtask

    // result side: random stall, check every taken result against the oldest prediction
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            result_stall <= ($urandom_range(99) < recv_idle_pct);
            if (result_valid && !result_stall)
            begin
                if (pending_medians.size() == 0)
                    report_mismatch("unexpected result, median", result.median_time, '0);
                else
                begin
                    if (result.median_time !== pending_medians[0].median_time)
                        report_mismatch("median_time", result.median_time,
                                        pending_medians[0].median_time);
                    if (result.window_count !== pending_medians[0].window_count)
                        report_mismatch("window_count", result.window_count,
                                        pending_medians[0].window_count);
                    if (pending_medians[0].window_count == WINDOW_SIZE)
                        full_windows++;
                    void'(pending_medians.pop_front());
                end
                results_checked++;
            end
        end
    end

    // watchdog: a long stretch with nothing moving on either channel ends the run
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((item_valid && !item_stall) || (result_valid && !result_stall))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("%0t watchdog: nothing moved for %0d cycles, %0d results outstanding",
                         $realtime, quiet_cycles, pending_medians.size());
                $display("[FAIL] regression broken");
                $finish;
            end
        end
    end

    // test sequence
    initial
    begin
        // reset held low from time zero, released at a rising edge
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // sender idles often, receiver stalls most of the time
        send_idle_pct = 38;
        recv_idle_pct = 83;
        test_window_edges();
        test_random_chains(280);

        // the other way round, with a full drain in the middle
        send_idle_pct = 83;
        recv_idle_pct = 38;
        test_drain_pause();
        test_random_chains(270);

        // no idling on either side
        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random_chains(300);

        // stop sending, let the last results come back, then a settle window
        item_valid <= 1'b0;
        wait_results_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (pending_medians.size() != 0)
            report_mismatch("results left over, count", pending_medians.size(), '0);

        $display("covered %0d items in %0d chain restarts, %0d results checked, %0d full",
                 items_sent, restarts_sent, results_checked, full_windows);
        $display("idle mixes: sender-heavy, receiver-heavy and none, plus one drain pause");
        if (error_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

### sim.f
+incdir+hw/rtl
hw/rtl/swm_pkg.sv
hw/rtl/swm_ram.sv
hw/rtl/swm_rank_unit.sv
hw/rtl/sliding_window_median_time_top.sv
hw/rtl/swm_checker.sv
sim/tb_top.sv
